>>> design/ptns_pkg.sv
// Package for the point table neighbor search block.
// Holds the command codes, the payload structs and the state machine type.
// No dependencies.
`default_nettype none
package ptns_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_NEAREST = 2'd1;
  localparam logic [1:0] CMD_NEIGHBOR = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int DistW = 50;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         entry_index;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic [23:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic [5:0] result_index;
    logic       found;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CENTRE_RD, ST_CENTRE_WT, ST_SCAN, ST_DIFF, ST_SQ, ST_SUM,
    ST_EMIT_PICK, ST_EMIT, ST_EMPTY
  } state_t;
endpackage
`default_nettype wire

>>> design/ptns_mem.sv
// Synchronous point memory with one write port and one registered read port.
// Depends on nothing; depth and address width come from parameters, the data width is fixed at 48 bits.
`default_nettype none
module ptns_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AddrW-1:0]  waddr,
  input  wire logic [47:0]       wdata,
  input  wire logic [AddrW-1:0]  raddr,
  output logic [47:0]            rdata
);
  logic [47:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/point_table_neighbor_search.sv
// Point table neighbor search: one command transaction at a time.
// A write is done on acceptance. A nearest query passes each entry in use through SCAN, DIFF,
// SQ and SUM, then gives its result (not-found when no entry is in use, as does a neighbor
// query with a bad centre). A neighbor query reads the centre, scans every entry in use, and
// gives each result after a selection pass over all 64 candidate slots plus a load state.
// The next transaction is accepted once the last result has left. Synchronous active-high
// reset clears control and point_count; the point memory is undefined until written.
`default_nettype none
module point_table_neighbor_search #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptns_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ptns_pkg::out_item_t    out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [0:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int Lim = (MAX_POINTS < 64) ? MAX_POINTS : 64;
  localparam int NW = 7;

  // Register file: point_count only.
  logic [6:0] point_count;
  assign pready = 1'b1;
  assign prdata = {25'd0, point_count};
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      point_count <= pwdata[6:0];
    end
  end

  logic [NW-1:0] n_used;
  assign n_used = (point_count > 7'(Lim)) ? 7'(Lim) : point_count;

  ptns_pkg::state_t state, state_next;
  ptns_pkg::in_item_t cur;
  logic [NW-1:0] scan_i;     // next entry to read
  logic [NW-1:0] proc_i;     // entry in the distance pipe
  logic signed [24:0] dx, dy;
  logic signed [49:0] prod_x, prod_y;
  logic [49:0] sqx, sqy;
  logic [ptns_pkg::DistW-1:0] sum_d;
  logic signed [23:0] ref_x, ref_y;
  logic [47:0] r2;
  logic [ptns_pkg::DistW-1:0] best_d;
  logic [5:0] best_i;
  logic have;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign sum_d = sqx + sqy;

  // Neighbor candidate list, held in a small synchronous memory with per-entry valid bits.
  logic [ptns_pkg::DistW-1:0] cand_d [64];
  logic [ptns_pkg::DistW-1:0] cand_rdata;
  logic [63:0] cand_v;
  logic cand_hit;
  logic [NW-1:0] sel_i;
  logic sel_last;

  // Memory.
  logic mem_we;
  logic [AddrW-1:0] mem_raddr;
  logic [47:0] mem_rdata;
  assign mem_we = in_valid && in_ready && in_data.cmd == ptns_pkg::CMD_WRITE
                  && 32'(in_data.entry_index) < MAX_POINTS;
  // The centre entry is read in the cycle after acceptance, the scan entries after that.
  assign mem_raddr = (state == ptns_pkg::ST_IDLE) ? AddrW'(in_data.entry_index)
                   : (state == ptns_pkg::ST_CENTRE_RD) ? AddrW'(cur.entry_index)
                                                       : AddrW'(scan_i);
  ptns_mem #(.Depth(MAX_POINTS), .AddrW(AddrW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(AddrW'(in_data.entry_index)),
    .wdata({in_data.coord_x, in_data.coord_y}), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // A new result is loaded only once the previous result has left the output register.
  logic out_busy;
  assign out_busy = out_valid;
  assign in_ready = state == ptns_pkg::ST_IDLE && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      ptns_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.cmd)
            ptns_pkg::CMD_NEAREST:
              state_next = (n_used == '0) ? ptns_pkg::ST_EMPTY : ptns_pkg::ST_SCAN;
            ptns_pkg::CMD_NEIGHBOR:
              state_next = (7'(in_data.entry_index) >= n_used) ? ptns_pkg::ST_EMPTY
                                                              : ptns_pkg::ST_CENTRE_RD;
            default: state_next = ptns_pkg::ST_IDLE;
          endcase
        end
      end
      ptns_pkg::ST_CENTRE_RD: state_next = ptns_pkg::ST_CENTRE_WT;
      ptns_pkg::ST_CENTRE_WT: state_next = ptns_pkg::ST_SCAN;
      ptns_pkg::ST_SCAN: state_next = ptns_pkg::ST_DIFF;
      ptns_pkg::ST_DIFF: state_next = ptns_pkg::ST_SQ;
      ptns_pkg::ST_SQ: state_next = ptns_pkg::ST_SUM;
      ptns_pkg::ST_SUM: begin
        if (proc_i + 1'b1 < n_used) begin
          state_next = ptns_pkg::ST_SCAN;
        end else if (cur.cmd == ptns_pkg::CMD_NEAREST) begin
          state_next = ptns_pkg::ST_IDLE;
        end else begin
          state_next = ptns_pkg::ST_EMIT_PICK;
        end
      end
      ptns_pkg::ST_EMIT_PICK: begin
        if (sel_i == NW'(65)) begin
          state_next = have ? ptns_pkg::ST_EMIT : ptns_pkg::ST_EMPTY;
        end
      end
      ptns_pkg::ST_EMIT: begin
        if (!out_busy) begin
          state_next = sel_last ? ptns_pkg::ST_IDLE : ptns_pkg::ST_EMIT_PICK;
        end
      end
      ptns_pkg::ST_EMPTY: if (!out_busy) state_next = ptns_pkg::ST_IDLE;
      default: state_next = ptns_pkg::ST_IDLE;
    endcase
  end

  // Scan of the candidate list: one slot read a cycle, compared in the following cycle against the
  // best so far; smallest distance wins, the lowest index on a tie.
  logic [5:0] sel_e;
  assign sel_e = sel_i[5:0];
  logic [5:0] pick_e;
  logic pick_ok;
  logic pick_better;
  assign pick_better = pick_ok && (!have || cand_rdata < best_d);

  assign cand_hit = state == ptns_pkg::ST_SUM && cur.cmd == ptns_pkg::CMD_NEIGHBOR
                    && proc_i[5:0] != cur.entry_index && sum_d <= 50'(r2);

  always_ff @(posedge clk) begin
    if (cand_hit) begin
      cand_d[proc_i[5:0]] <= sum_d;
    end
    cand_rdata <= cand_d[sel_e];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptns_pkg::ST_IDLE;
      out_valid <= 1'b0;
      cand_v <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ptns_pkg::ST_IDLE: begin
          cur <= in_data;
          scan_i <= '0;
          have <= 1'b0;
          cand_v <= '0;
          ref_x <= in_data.coord_x;
          ref_y <= in_data.coord_y;
          r2 <= 48'(in_data.radius) * 48'(in_data.radius);
        end
        ptns_pkg::ST_CENTRE_WT: begin
          ref_x <= mem_rdata[47:24];
          ref_y <= mem_rdata[23:0];
        end
        ptns_pkg::ST_SCAN: begin
          proc_i <= scan_i;
          scan_i <= scan_i + 1'b1;
        end
        ptns_pkg::ST_DIFF: begin
          dx <= 25'(signed'(mem_rdata[47:24])) - 25'(ref_x);
          dy <= 25'(signed'(mem_rdata[23:0])) - 25'(ref_y);
        end
        ptns_pkg::ST_SQ: begin
          sqx <= unsigned'(prod_x);
          sqy <= unsigned'(prod_y);
        end
        ptns_pkg::ST_SUM: begin
          if (cur.cmd == ptns_pkg::CMD_NEAREST) begin
            if (!have || sum_d < best_d) begin
              best_d <= sum_d;
              best_i <= proc_i[5:0];
              have <= 1'b1;
              if (proc_i + 1'b1 >= n_used) begin
                out_data <= '{result_index: proc_i[5:0], found: 1'b1, last: 1'b1};
              end
            end
            if (proc_i + 1'b1 >= n_used) begin
              out_valid <= 1'b1;
              if (!(!have || sum_d < best_d)) begin
                out_data <= '{result_index: best_i, found: 1'b1, last: 1'b1};
              end
            end
          end else begin
            if (cand_hit) begin
              cand_v[proc_i[5:0]] <= 1'b1;
            end
            if (proc_i + 1'b1 >= n_used) begin
              sel_i <= '0;
              pick_ok <= 1'b0;
              have <= 1'b0;
            end
          end
        end
        ptns_pkg::ST_EMIT_PICK: begin
          if (sel_i != NW'(65)) begin
            sel_i <= sel_i + 1'b1;
          end
          pick_e <= sel_e;
          pick_ok <= sel_i < NW'(64) && cand_v[sel_e];
          if (pick_better) begin
            best_d <= cand_rdata;
            best_i <= pick_e;
            have <= 1'b1;
          end
          sel_last <= (cand_v & ~(64'd1 << best_i)) == '0;
        end
        ptns_pkg::ST_EMIT: begin
          if (!out_busy) begin
            out_valid <= 1'b1;
            out_data <= '{result_index: best_i, found: 1'b1, last: sel_last};
            cand_v[best_i] <= 1'b0;
            sel_i <= '0;
            have <= 1'b0;
          end
        end
        ptns_pkg::ST_EMPTY: begin
          if (!out_busy) begin
            out_valid <= 1'b1;
            out_data <= '{result_index: 6'd0, found: 1'b0, last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  property p_hold;
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid;
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped while stalled");
  a_noaccept: assert property (@(posedge clk) disable iff (rst)
    state != ptns_pkg::ST_IDLE |-> !in_ready) else $error("accept while busy");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.last && out_data.result_index == 6'd0)
    else $error("empty result malformed");
endmodule
`default_nettype wire
